// ----- design/mrb_pkg.sv -----
// shared types, field widths, request and coefficient codes for the resonator bank
// no dependencies; used by mrb_mode and modal_resonator_bank
package mrb_pkg;

    localparam int MODE_COUNT_DEFAULT     = 8;
    localparam int SAMPLE_BITS_DEFAULT    = 24;
    localparam int COEF_FRAC_BITS_DEFAULT = 30;

    localparam int REQ_BITS        = 2;
    localparam int MODE_INDEX_BITS = 3;
    localparam int COEF_SEL_BITS   = 2;
    localparam int COEF_BITS       = 32;
    localparam int MODE_OUT_BITS   = 32;
    localparam int COEFS_PER_MODE  = 3;

    localparam logic [REQ_BITS-1:0] REQ_AUDIO = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_COEF  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

    localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_GAIN = 2'd0;
    localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_A1   = 2'd1;
    localparam logic [COEF_SEL_BITS-1:0] COEF_SEL_A2   = 2'd2;

    typedef struct packed {
        logic signed [MODE_OUT_BITS-1:0] y;
        logic                            clip;
    } mode_result_t;

endpackage

// ----- design/mrb_mode.sv -----
// one two-pole resonator: y = round((g*(x - x2) - a1*y1 - a2*y2) / 2^frac), saturated to 32 bits
// depends on mrb_pkg
module mrb_mode #(
    parameter int SAMPLE_BITS    = mrb_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = mrb_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic signed [mrb_pkg::COEF_BITS-1:0]     gain,
    input  logic signed [mrb_pkg::COEF_BITS-1:0]     a1,
    input  logic signed [mrb_pkg::COEF_BITS-1:0]     a2,
    input  logic signed [SAMPLE_BITS-1:0]            x,
    input  logic signed [SAMPLE_BITS-1:0]            x2,
    input  logic signed [mrb_pkg::MODE_OUT_BITS-1:0] y1,
    input  logic signed [mrb_pkg::MODE_OUT_BITS-1:0] y2,
    output mrb_pkg::mode_result_t                    res
);

    localparam int CB    = mrb_pkg::COEF_BITS;
    localparam int YB    = mrb_pkg::MODE_OUT_BITS;
    localparam int DB    = SAMPLE_BITS + 1;
    localparam int P0B   = CB + DB;
    localparam int P1B   = CB + YB;
    localparam int PMAX  = (P0B > P1B) ? P0B : P1B;
    localparam int ACCB  = PMAX + 2;
    localparam int SHB   = ACCB - COEF_FRAC_BITS;

    localparam logic signed [ACCB-1:0] RND =
        {{(ACCB-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SHB-1:0] Y_HI = {{(SHB-YB+1){1'b0}}, {(YB-1){1'b1}}};
    localparam logic signed [SHB-1:0] Y_LO = ~Y_HI;

    logic signed [DB-1:0]   diff;
    logic signed [P0B-1:0]  p0;
    logic signed [P1B-1:0]  p1;
    logic signed [P1B-1:0]  p2;
    logic signed [ACCB-1:0] acc;
    logic signed [SHB-1:0]  shifted;

    assign diff    = DB'(x) - DB'(x2);
    assign p0      = P0B'(gain) * P0B'(diff);
    assign p1      = P1B'(a1) * P1B'(y1);
    assign p2      = P1B'(a2) * P1B'(y2);
    assign acc     = ACCB'(p0) - ACCB'(p1) - ACCB'(p2) + RND;
    assign shifted = acc[ACCB-1:COEF_FRAC_BITS];

    always_comb
    begin
        if (shifted > Y_HI)
        begin
            res.y    = Y_HI[YB-1:0];
            res.clip = 1'b1;
        end
        else if (shifted < Y_LO)
        begin
            res.y    = Y_LO[YB-1:0];
            res.clip = 1'b1;
        end
        else
        begin
            res.y    = shifted[YB-1:0];
            res.clip = 1'b0;
        end
    end

endmodule

// ----- design/modal_resonator_bank.sv -----
// top level of the modal resonator bank: input register, parallel resonators, summing stage
// depends on mrb_pkg and mrb_mode
// an audio transfer passes the input register, mode stage and output register in order
// throughput: one item per cycle unless stalled; feedback closes in the single mode stage
// coefficient writes and clears take effect the cycle after acceptance and give no result
// reset: coefficients and histories cleared (bank silent), all stages empty
module modal_resonator_bank #(
    parameter int MODE_COUNT     = mrb_pkg::MODE_COUNT_DEFAULT,
    parameter int SAMPLE_BITS    = mrb_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = mrb_pkg::COEF_FRAC_BITS_DEFAULT,
    localparam int IN_FIELD_BITS = SAMPLE_BITS + mrb_pkg::MODE_INDEX_BITS
                                   + mrb_pkg::COEF_SEL_BITS + mrb_pkg::COEF_BITS,
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // sample_in, mode_index, coef_select, coef_value, zero fill
    input  logic [IN_DATA_BITS-1:0]      s_axis_tdata,
    // req_type
    input  logic [mrb_pkg::REQ_BITS-1:0] s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // sample_out, zero fill
    output logic [OUT_DATA_BITS-1:0]     m_axis_tdata,
    // clipped
    output logic                         m_axis_tuser
);

    localparam int MIB  = mrb_pkg::MODE_INDEX_BITS;
    localparam int CSB  = mrb_pkg::COEF_SEL_BITS;
    localparam int CB   = mrb_pkg::COEF_BITS;
    localparam int YB   = mrb_pkg::MODE_OUT_BITS;
    localparam int NC   = mrb_pkg::COEFS_PER_MODE;
    localparam int MI_LO = SAMPLE_BITS;
    localparam int CS_LO = MI_LO + MIB;
    localparam int CV_LO = CS_LO + CSB;
    localparam int SUMB = YB + 1 + $clog2(MODE_COUNT);

    localparam logic signed [SUMB-1:0] SUM_HI =
        {{(SUMB-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUMB-1:0] SUM_LO = ~SUM_HI;

    // input stage
    logic                           s0_valid_reg;
    logic [mrb_pkg::REQ_BITS-1:0]   s0_req_reg;
    logic signed [SAMPLE_BITS-1:0]  s0_sample_reg;
    logic [MIB-1:0]                 s0_mode_reg;
    logic [CSB-1:0]                 s0_sel_reg;
    logic signed [CB-1:0]           s0_value_reg;

    // state
    logic signed [CB-1:0]           coef_reg [MODE_COUNT][NC];
    logic signed [YB-1:0]           y1_reg [MODE_COUNT];
    logic signed [YB-1:0]           y2_reg [MODE_COUNT];
    logic signed [SAMPLE_BITS-1:0]  x1_reg;
    logic signed [SAMPLE_BITS-1:0]  x2_reg;

    // mode stage
    logic                           s1_valid_reg;
    logic signed [YB-1:0]           s1_y_reg [MODE_COUNT];
    logic [MODE_COUNT-1:0]          s1_clip_reg;

    // output stage
    logic                           out_valid_reg;
    logic [SAMPLE_BITS-1:0]         out_sample_reg;
    logic                           out_clip_reg;

    logic                           out_free;
    logic                           s1_free;
    logic                           s0_fire;
    logic                           s0_free;
    logic                           audio_fire;
    logic                           coef_fire;
    logic                           clear_fire;
    mrb_pkg::mode_result_t          mode_res [MODE_COUNT];
    logic signed [SUMB-1:0]         total;
    logic [SAMPLE_BITS-1:0]         sample_next;
    logic                           clip_next;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign s0_fire    = s0_valid_reg && ((s0_req_reg != mrb_pkg::REQ_AUDIO) || s1_free);
    assign s0_free    = !s0_valid_reg || s0_fire;
    assign audio_fire = s0_fire && (s0_req_reg == mrb_pkg::REQ_AUDIO);
    assign coef_fire  = s0_fire && (s0_req_reg == mrb_pkg::REQ_COEF);
    assign clear_fire = s0_fire && (s0_req_reg == mrb_pkg::REQ_CLEAR);

    assign s_axis_tready = s0_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_sample_reg);
    assign m_axis_tuser  = out_clip_reg;

    for (genvar m = 0; m < MODE_COUNT; m++)
    begin : g_mode
        mrb_mode #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_mode (
            .gain (coef_reg[m][mrb_pkg::COEF_SEL_GAIN]),
            .a1   (coef_reg[m][mrb_pkg::COEF_SEL_A1]),
            .a2   (coef_reg[m][mrb_pkg::COEF_SEL_A2]),
            .x    (s0_sample_reg),
            .x2   (x2_reg),
            .y1   (y1_reg[m]),
            .y2   (y2_reg[m]),
            .res  (mode_res[m])
        );
    end

    always_comb
    begin
        total = '0;
        for (int m = 0; m < MODE_COUNT; m++)
        begin
            total = total + SUMB'(s1_y_reg[m]);
        end
        clip_next = |s1_clip_reg;
        if (total > SUM_HI)
        begin
            sample_next = SUM_HI[SAMPLE_BITS-1:0];
            clip_next   = 1'b1;
        end
        else if (total < SUM_LO)
        begin
            sample_next = SUM_LO[SAMPLE_BITS-1:0];
            clip_next   = 1'b1;
        end
        else
        begin
            sample_next = total[SAMPLE_BITS-1:0];
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            for (int m = 0; m < MODE_COUNT; m++)
            begin
                y1_reg[m] <= '0;
                y2_reg[m] <= '0;
                for (int k = 0; k < NC; k++)
                begin
                    coef_reg[m][k] <= '0;
                end
            end
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= s_axis_tvalid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= audio_fire;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (audio_fire)
            begin
                x1_reg <= s0_sample_reg;
                x2_reg <= x1_reg;
                for (int m = 0; m < MODE_COUNT; m++)
                begin
                    y1_reg[m] <= mode_res[m].y;
                    y2_reg[m] <= y1_reg[m];
                end
            end
            else if (clear_fire)
            begin
                x1_reg <= '0;
                x2_reg <= '0;
                for (int m = 0; m < MODE_COUNT; m++)
                begin
                    y1_reg[m] <= '0;
                    y2_reg[m] <= '0;
                end
            end
            if (coef_fire)
            begin
                for (int m = 0; m < MODE_COUNT; m++)
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        if ((int'(s0_mode_reg) == m) && (int'(s0_sel_reg) == k))
                        begin
                            coef_reg[m][k] <= s0_value_reg;
                        end
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s0_free && s_axis_tvalid)
        begin
            s0_req_reg    <= s_axis_tuser;
            s0_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            s0_mode_reg   <= s_axis_tdata[CS_LO-1:MI_LO];
            s0_sel_reg    <= s_axis_tdata[CV_LO-1:CS_LO];
            s0_value_reg  <= s_axis_tdata[CV_LO+CB-1:CV_LO];
        end
        if (audio_fire)
        begin
            for (int m = 0; m < MODE_COUNT; m++)
            begin
                s1_y_reg[m]    <= mode_res[m].y;
                s1_clip_reg[m] <= mode_res[m].clip;
            end
        end
        if (out_free && s1_valid_reg)
        begin
            out_sample_reg <= sample_next;
            out_clip_reg   <= clip_next;
        end
    end

    a_clear_zeroes_inputs: assert property (@(posedge clk) disable iff (!rst_n)
        clear_fire |=> (x1_reg == '0) && (x2_reg == '0))
        else $error("input history not zero after clear");

    a_result_from_mode_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result transfer without a mode stage entry");

    a_mode_stage_from_audio: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_free && !audio_fire) |=> !s1_valid_reg)
        else $error("mode stage loaded by a non-audio transfer");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s0_valid_reg && s1_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

endmodule
